FILE: design/hps_pkg.sv
// Shared types and constants for the haptic pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

package hps_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_LOAD  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_PATTERN_LENGTH = 1'b0;
  localparam logic CFG_MAX_STRENGTH   = 1'b1;

  // Field widths fixed by the interface.
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned DUR_IN_W   = 16;
  localparam int unsigned CFG_DATA_W = 8;

  // Reset value of the strength limit (full strength).
  localparam logic [LEVEL_W-1:0] MAX_STRENGTH_RST = 8'hFF;

  // One incoming request.
  typedef struct packed {
    logic [1:0]          opcode;
    logic [IDX_W-1:0]    entry_index;
    logic [LEVEL_W-1:0]  entry_magnitude;
    logic [DUR_IN_W-1:0] entry_duration;
  } in_req_t;

  // One result item.
  typedef struct packed {
    logic [LEVEL_W-1:0] drive_level;
    logic               drive_enable;
    logic               pattern_active;
    logic [IDX_W-1:0]   step_position;
    logic               step_started;
  } out_res_t;

endpackage

`default_nettype wire

FILE: design/haptic_pattern_sequencer.sv
// Top level of the haptic pattern sequencer: step table, playback state and output skid.
`timescale 1ns / 1ps
`default_nettype none

// Plays a stored pattern of up to MAX_STEPS steps, each a magnitude and a duration in
// millisecond ticks. Every request (tick, start, stop or table load) produces exactly one
// result that shows the playback state after that request. A request is processed in the
// cycle it is accepted and its result is registered, so one request is taken every clock
// while in_stall is low. The step table is read ahead into registers that hold entry 0
// and the entry after the current step, so the limit is the update of the playback
// registers together with the level clip. A two-entry output buffer
// (result register plus skid register) lets a request be accepted while one result waits
// on out_stall; in_stall rises only when both entries are full. Configuration writes are
// taken at any time and are meant to be issued while no request is in flight.
module haptic_pattern_sequencer #(
  parameter int unsigned MAX_STEPS     = 16,
  parameter int unsigned DURATION_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // Request channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire hps_pkg::in_req_t             in_data,
  // Result channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output hps_pkg::out_res_t                 out_data,
  // Configuration port
  input  wire                               cfg_we,
  input  wire                               cfg_index,
  input  wire [hps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import hps_pkg::*;

  // Width of a step index, and of the wider compare domain for index against length.
  localparam int unsigned PW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned CW  = ((PW + 1) > (LEN_W + 1)) ? (PW + 1) : (LEN_W + 1);
  localparam int unsigned EIW = (PW > IDX_W) ? PW : IDX_W;
  localparam int unsigned DW  = DURATION_BITS;
  localparam logic [CW-1:0] MAX_STEPS_C = CW'(MAX_STEPS);

  // Step table, written by load requests and read ahead into registers.
  logic [LEVEL_W-1:0] mag_table [MAX_STEPS];
  logic [DW-1:0]      dur_table [MAX_STEPS];

  // Registered table reads: entry 0 for a start, the following entry for a tick.
  logic [LEVEL_W-1:0] first_mag_r, ahead_mag_r;
  logic [DW-1:0]      first_dur_r, ahead_dur_r;
  logic [PW-1:0]      pos_after;
  logic [PW-1:0]      ahead_idx;

  // Playback state.
  logic               running_r, running_nxt;
  logic [PW-1:0]      position_r, position_nxt;
  logic [DW-1:0]      ticks_r, ticks_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               started;

  // Configuration registers.
  logic [LEN_W-1:0]   pattern_length_r;
  logic [LEVEL_W-1:0] max_strength_r;

  // Output buffer.
  logic               out_valid_r, skid_valid_r;
  out_res_t           out_data_r, skid_data_r;
  out_res_t           res_nxt;

  logic               accept;
  logic [CW-1:0]      eff_len;
  logic [CW-1:0]      next_c;
  logic [PW-1:0]      step_idx;
  logic [LEVEL_W-1:0] step_mag;
  logic [DW-1:0]      step_dur;
  logic [LEVEL_W-1:0] step_level;
  logic [EIW-1:0]     load_idx_ext;
  logic               load_ok;
  logic [DW-1:0]      load_dur;
  logic               load_we;
  logic [PW-1:0]      load_addr;

  assign accept   = in_valid && !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Effective length is the configured length capped at the table depth.
  always_comb begin
    eff_len = CW'(pattern_length_r);
    if (eff_len > MAX_STEPS_C) begin
      eff_len = MAX_STEPS_C;
    end
  end

  assign next_c = CW'(position_r) + CW'(1);

  // Start begins at step 0; a tick that ends a step begins the following one.
  assign step_idx   = (in_data.opcode == OP_START) ? '0 : next_c[PW-1:0];
  assign step_mag   = (in_data.opcode == OP_START) ? first_mag_r : ahead_mag_r;
  assign step_dur   = (in_data.opcode == OP_START) ? first_dur_r : ahead_dur_r;
  assign step_level = (step_mag > max_strength_r) ? max_strength_r : step_mag;

  // Playback state update for the current request.
  always_comb begin
    running_nxt  = running_r;
    position_nxt = position_r;
    ticks_nxt    = ticks_r;
    level_nxt    = level_r;
    started      = 1'b0;
    case (in_data.opcode)
      OP_TICK: begin
        if (running_r) begin
          if (ticks_r > DW'(1)) begin
            ticks_nxt = ticks_r - DW'(1);
          end else if (next_c >= eff_len) begin
            running_nxt  = 1'b0;
            position_nxt = '0;
            ticks_nxt    = '0;
            level_nxt    = '0;
          end else begin
            running_nxt  = 1'b1;
            position_nxt = step_idx;
            ticks_nxt    = (step_dur == '0) ? DW'(1) : step_dur;
            level_nxt    = step_level;
            started      = 1'b1;
          end
        end
      end
      OP_START: begin
        if (eff_len != '0) begin
          running_nxt  = 1'b1;
          position_nxt = '0;
          ticks_nxt    = (step_dur == '0) ? DW'(1) : step_dur;
          level_nxt    = step_level;
          started      = 1'b1;
        end else begin
          running_nxt  = 1'b0;
          position_nxt = '0;
          ticks_nxt    = '0;
          level_nxt    = '0;
        end
      end
      OP_STOP: begin
        running_nxt  = 1'b0;
        position_nxt = '0;
        ticks_nxt    = '0;
        level_nxt    = '0;
      end
      default: begin
        // Table loads leave the playing step untouched.
      end
    endcase
  end

  // Result seen after this request.
  always_comb begin
    logic [EIW-1:0] pos_ext;
    pos_ext                = EIW'(position_nxt);
    res_nxt.drive_level    = running_nxt ? level_nxt : '0;
    res_nxt.drive_enable   = running_nxt && (level_nxt != '0);
    res_nxt.pattern_active = running_nxt;
    res_nxt.step_position  = running_nxt ? pos_ext[IDX_W-1:0] : '0;
    res_nxt.step_started   = started;
  end

  // Playback and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r        <= 1'b0;
      position_r       <= '0;
      ticks_r          <= '0;
      level_r          <= '0;
      pattern_length_r <= '0;
      max_strength_r   <= MAX_STRENGTH_RST;
    end else begin
      if (accept) begin
        running_r  <= running_nxt;
        position_r <= position_nxt;
        ticks_r    <= ticks_nxt;
        level_r    <= level_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[LEN_W-1:0];
          CFG_MAX_STRENGTH:   max_strength_r   <= cfg_wdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Table write; an index past the table is dropped.
  assign load_idx_ext = EIW'(in_data.entry_index);
  assign load_ok      = (CW'(in_data.entry_index) < MAX_STEPS_C);
  assign load_dur     = DW'(in_data.entry_duration);
  assign load_we      = accept && (in_data.opcode == OP_LOAD) && load_ok;
  assign load_addr    = load_idx_ext[PW-1:0];

  always_ff @(posedge clk) begin
    if (load_we) begin
      mag_table[load_addr] <= in_data.entry_magnitude;
      dur_table[load_addr] <= load_dur;
    end
  end

  // The entry after the step that is current once this edge has passed.
  assign pos_after = !rst_n ? '0 : (accept ? position_nxt : position_r);
  assign ahead_idx = pos_after + PW'(1);

  // Read-ahead registers; a load in the same cycle is passed straight through.
  always_ff @(posedge clk) begin
    if (load_we && (load_addr == '0)) begin
      first_mag_r <= in_data.entry_magnitude;
      first_dur_r <= load_dur;
    end else begin
      first_mag_r <= mag_table[0];
      first_dur_r <= dur_table[0];
    end
    if (load_we && (load_addr == ahead_idx)) begin
      ahead_mag_r <= in_data.entry_magnitude;
      ahead_dur_r <= load_dur;
    end else begin
      ahead_mag_r <= mag_table[ahead_idx];
      ahead_dur_r <= dur_table[ahead_idx];
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r  <= skid_valid_r || accept;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_nxt;
    end else if (accept) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: design/hps_checker.sv
// Port-level checks for the haptic pattern sequencer and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module hps_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_stall,
  input wire                     out_valid,
  input wire                     out_stall,
  input wire hps_pkg::out_res_t  out_data
);

  import hps_pkg::*;

  // A result that starts a step always shows a playing pattern.
  a_started_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_started |-> out_data.pattern_active)
    else $error("step_started without pattern_active");

  // The drive enable follows a nonzero level.
  a_enable_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.drive_enable == (out_data.drive_level != '0)))
    else $error("drive_enable disagrees with drive_level");

  // When idle, level and position read zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pattern_active |->
      (out_data.drive_level == '0) && (out_data.step_position == '0))
    else $error("idle result with nonzero level or position");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The input is held off only while a result is waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall with no result pending");

endmodule

bind haptic_pattern_sequencer hps_checker u_hps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
